// ----- hw/rtl/bfa_pkg.sv -----
// Shared widths, operation codes and register indexes for the bitmap allocator.
package bfa_pkg;

  localparam int BITMAP_BYTES = 1024;
  localparam int RAM_AW       = $clog2(BITMAP_BYTES);
  localparam int CNT_W        = $clog2(BITMAP_BYTES + 1);
  localparam int POS_W        = 14;
  localparam int ADDR_W       = 10;
  localparam int BYTE_W       = 8;
  localparam int CFG_IDX_W    = 2;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_FIND = 2'd1,
    OP_MARK = 2'd2,
    OP_READ = 2'd3
  } op_e;

  localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED  = CFG_IDX_W'(1);

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] pos;
  } byte_hit_t;

endpackage

// ----- hw/rtl/bfa_ram.sv -----
// Generic single-port RAM with registered read data.
module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hw/rtl/bfa_byte_check.sv -----
// Finds the lowest clear bit of one bitmap byte whose position lies above the reserved count.
module bfa_byte_check
  import bfa_pkg::*;
(
  input  logic [BYTE_W-1:0] byte_data,
  input  logic [RAM_AW-1:0] byte_idx,
  input  logic [POS_W-1:0]  reserved_count,
  output byte_hit_t         result
);

  logic [POS_W-1:0] base;

  assign base = POS_W'({byte_idx, 3'b000}) + POS_W'(1);

  always_comb begin
    logic [POS_W-1:0] p;
    result = '0;
    // walk downward so the lowest qualifying bit wins
    for (int b = BYTE_W - 1; b >= 0; b--) begin
      p = base + POS_W'(b);
      if (!byte_data[b] && (p > reserved_count)) begin
        result.hit = 1'b1;
        result.pos = p;
      end
    end
  end

endmodule

// ----- hw/rtl/bitmap_first_free_allocator.sv -----
// Top level of the bitmap first-free allocator: sequencer, bitmap RAM and result register.
//
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data         | in
//  in      | in_valid in_ready op byte_address position     | in
//          | load_byte                                      |
//  out     | out_valid out_ready found free_position        | out
//          | read_byte                                      |
//
// Load and an out-of-range mark go from idle straight to the done state; read and an
// in-range mark pass through the wait state (one RAM read, then capture or write back).
// Find streams one bitmap byte per cycle through the byte checker, a rate set by the
// single RAM read port, over at most min(bit_count/8, 1024) bytes (all when nothing is free).
// in_ready is high only while the sequencer is idle; a finished result sits in
// the output register, so a new item may be taken while it waits for out_ready.
// Reset clears the control state, out_valid and the two configuration registers; bitmap bytes are valid once loaded.
module bitmap_first_free_allocator
  import bfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           op,
  input  logic [ADDR_W-1:0]    byte_address,
  input  logic [POS_W-1:0]     position,
  input  logic [BYTE_W-1:0]    load_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 found,
  output logic [POS_W-1:0]     free_position,
  output logic [BYTE_W-1:0]    read_byte
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WAIT = 4'b0010,
    S_FIND = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [POS_W-1:0]  bit_count, reserved_count;
  op_e               op_q;
  logic              addr_ok_q;
  logic [RAM_AW-1:0] mark_k;
  logic [2:0]        mark_bit;
  logic [CNT_W-1:0]  issue_idx;
  logic              chk_vld;
  logic [RAM_AW-1:0] chk_idx;
  logic              res_found;
  logic [POS_W-1:0]  res_pos;
  logic [BYTE_W-1:0] res_byte;

  logic [CNT_W-1:0]  bc_bytes, nbytes;
  logic [POS_W-1:0]  pos_m1;
  logic              mark_ok, addr_ok, issue_go, accept, out_free;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_addr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;
  byte_hit_t         chk_res;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // whole bytes covered by bit_count, saturated to the bitmap size
  assign bc_bytes = CNT_W'(bit_count[POS_W-1:3]);
  assign nbytes   = (bc_bytes > CNT_W'(BITMAP_BYTES)) ? CNT_W'(BITMAP_BYTES) : bc_bytes;

  assign pos_m1   = position - POS_W'(1);
  assign mark_ok  = (position != '0) && (CNT_W'(pos_m1[POS_W-1:3]) < nbytes);
  assign addr_ok  = {1'b0, byte_address} < CNT_W'(BITMAP_BYTES);
  assign issue_go = issue_idx < nbytes;

  bfa_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BITMAP_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  bfa_byte_check u_check (
    .byte_data      (ram_rdata),
    .byte_idx       (chk_idx),
    .reserved_count (reserved_count),
    .result         (chk_res)
  );

  // RAM port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = byte_address[RAM_AW-1:0];
    ram_wdata = load_byte;
    unique case (state)
      S_IDLE: begin
        if (accept && op_e'(op) == OP_LOAD && addr_ok) begin
          ram_we = 1'b1;
        end else if (accept && op_e'(op) == OP_MARK) begin
          ram_addr = pos_m1[RAM_AW+2:3];
        end
      end
      S_WAIT: begin
        ram_addr  = mark_k;
        ram_wdata = ram_rdata | (BYTE_W'(1) << mark_bit);
        ram_we    = (op_q == OP_MARK);
      end
      S_FIND: ram_addr = issue_idx[RAM_AW-1:0];
      S_DONE: ram_addr = mark_k;
      default: ram_addr = byte_address[RAM_AW-1:0];
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op_e'(op))
            OP_LOAD: state_next = S_DONE;
            OP_FIND: state_next = S_FIND;
            OP_MARK: state_next = mark_ok ? S_WAIT : S_DONE;
            OP_READ: state_next = S_WAIT;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_WAIT: state_next = S_DONE;
      S_FIND: begin
        if ((chk_vld && chk_res.hit) || (!chk_vld && !issue_go)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      chk_vld        <= 1'b0;
      bit_count      <= '0;
      reserved_count <= '0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BIT_COUNT) bit_count <= cfg_data;
        if (cfg_index == CFG_RESERVED) reserved_count <= cfg_data;
      end

      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q      <= op_e'(op);
            addr_ok_q <= addr_ok;
            mark_k    <= pos_m1[RAM_AW+2:3];
            mark_bit  <= pos_m1[2:0];
            issue_idx <= '0;
            chk_vld   <= 1'b0;
            res_found <= 1'b0;
            res_pos   <= '0;
            res_byte  <= '0;
          end
        end
        S_WAIT: begin
          if (op_q == OP_READ && addr_ok_q) res_byte <= ram_rdata;
        end
        S_FIND: begin
          // read of byte issue_idx overlaps the check of the previous byte
          issue_idx <= issue_idx + CNT_W'(1);
          chk_vld   <= issue_go && !(chk_vld && chk_res.hit);
          chk_idx   <= issue_idx[RAM_AW-1:0];
          if (chk_vld && chk_res.hit) begin
            res_found <= 1'b1;
            res_pos   <= chk_res.pos;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            found         <= res_found;
            free_position <= res_pos;
            read_byte     <= res_byte;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/bfa_checker.sv -----
// Port-level assertions for the bitmap allocator, bound to the top level.
module bfa_checker
  import bfa_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 found,
  input logic [POS_W-1:0]     free_position,
  input logic [BYTE_W-1:0]    read_byte
);

  // a taken item makes the block busy: in_ready falls once an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an item was taken");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found) &&
      $stable(free_position) && $stable(read_byte))
    else $error("stalled result changed");

  a_found_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (found == (free_position != '0)))
    else $error("found flag disagrees with free_position");

  a_find_no_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> read_byte == '0)
    else $error("find result carries a read byte");

endmodule

bind bitmap_first_free_allocator bfa_checker u_bfa_checker (.*);

// ----- sim/testbench.sv -----
// Self-checking bench for the bitmap first-free allocator: load, find, mark and read traffic.
`timescale 1ns / 1ps

module testbench
  import bfa_pkg::*;
();

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int POS_MAX = (1 << POS_W) - 1;

  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] rd;
  } alloc_reply_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [POS_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           op = '0;
  logic [ADDR_W-1:0]    byte_address = '0;
  logic [POS_W-1:0]     position = '0;
  logic [BYTE_W-1:0]    load_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 found;
  logic [POS_W-1:0]     free_position;
  logic [BYTE_W-1:0]    read_byte;

  // bench copy of the allocator state
  logic [BYTE_W-1:0] model_map [BITMAP_BYTES];
  logic [POS_W-1:0]  model_bits = '0;
  logic [POS_W-1:0]  model_rsv = '0;

  // bytes written so far; finds only cover a fully written prefix
  bit loaded [BITMAP_BYTES];
  int loaded_list [$];
  int loaded_prefix = 0;

  alloc_reply_t reply_q [$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int n_loads = 0, n_finds = 0, n_marks = 0, n_reads = 0, n_cfg = 0;
  int n_hits = 0, n_misses = 0;

  bitmap_first_free_allocator dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .byte_address(byte_address),
    .position(position), .load_byte(load_byte),
    .out_valid(out_valid), .out_ready(out_ready), .found(found),
    .free_position(free_position), .read_byte(read_byte)
  );

  always #2 clk = ~clk;

  function automatic int covered_bytes();
    int n;
    n = int'(model_bits) / 8;
    if (n > BITMAP_BYTES) n = BITMAP_BYTES;
    return n;
  endfunction

  function automatic alloc_reply_t bitmap_step(op_e kind, logic [ADDR_W-1:0] addr,
                                               logic [POS_W-1:0] pos, logic [BYTE_W-1:0] val);
    alloc_reply_t r;
    bit done;
    int p;
    int idx;
    r = '0;
    done = 1'b0;
    case (kind)
      OP_LOAD: model_map[addr] = val;
      OP_FIND: begin
        for (int k = 0; k < covered_bytes() && !done; k++)
          for (int b = 0; b < 8 && !done; b++) begin
            p = 8 * k + b + 1;
            if (p > int'(model_rsv) && !model_map[k][b]) begin
              r.found = 1'b1;
              r.pos = POS_W'(p);
              done = 1'b1;
            end
          end
      end
      OP_MARK: begin
        if (pos >= 1 && int'(pos) <= covered_bytes() * 8) begin
          idx = int'(pos) - 1;
          model_map[idx >> 3][idx & 7] = 1'b1;
        end
      end
      default: r.rd = model_map[addr];
    endcase
    return r;
  endfunction

  task automatic note_loaded(input int addr);
    if (!loaded[addr]) begin
      loaded[addr] = 1'b1;
      loaded_list.push_back(addr);
    end
    while (loaded_prefix < BITMAP_BYTES && loaded[loaded_prefix]) loaded_prefix++;
  endtask

  // call at a rising edge; returns at the edge where the item was taken
  task automatic send_item(input op_e kind, input int addr, input int pos, input int val);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= kind;
    byte_address <= ADDR_W'(addr);
    position     <= POS_W'(pos);
    load_byte    <= BYTE_W'(val);
    do @(posedge clk); while (!in_ready);
    reply_q.push_back(bitmap_step(kind, ADDR_W'(addr), POS_W'(pos), BYTE_W'(val)));
    case (kind)
      OP_LOAD: begin
        n_loads++;
        note_loaded(addr);
      end
      OP_FIND: n_finds++;
      OP_MARK: n_marks++;
      default: n_reads++;
    endcase
  endtask

  // drop valid and wait until every outstanding result is back
  task automatic settle();
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_regs(input int bits, input int rsv, input bit spare);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [POS_W-1:0]     val [4];
    int n;
    idx = '{CFG_BIT_COUNT, CFG_RESERVED, CFG_SPARE_2, CFG_SPARE_3};
    val = '{POS_W'(bits), POS_W'(rsv), POS_W'($urandom), POS_W'(POS_MAX)};
    n = spare ? 4 : 2;
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      if (idx[i] == CFG_BIT_COUNT) model_bits = val[i];
      else if (idx[i] == CFG_RESERVED) model_rsv = val[i];
      n_cfg++;
    end
    cfg_valid <= 1'b0;
  endtask

  // random op; anything that would touch an unwritten byte becomes a load of it
  task automatic random_item();
    int sel, addr, pos, val, lim;
    sel  = $urandom_range(99);
    addr = $urandom_range(BITMAP_BYTES - 1);
    val  = $urandom_range(1) ? 8'hFF : $urandom_range(255);
    lim  = covered_bytes() * 8;
    if (sel < 30) begin
      if (loaded_prefix < BITMAP_BYTES && $urandom_range(99) < 60) addr = loaded_prefix;
      send_item(OP_LOAD, addr, $urandom_range(POS_MAX), val);
    end else if (sel < 50) begin
      if (covered_bytes() <= loaded_prefix)
        send_item(OP_FIND, addr, $urandom_range(POS_MAX), $urandom_range(255));
      else
        send_item(OP_LOAD, loaded_prefix, $urandom_range(POS_MAX), val);
    end else if (sel < 75) begin
      if (lim > 0 && $urandom_range(99) < 80) pos = $urandom_range(1, lim);
      else if ($urandom_range(3) == 0) pos = 0;
      else pos = $urandom_range(POS_MAX);
      if (pos >= 1 && pos <= lim && !loaded[(pos - 1) >> 3])
        send_item(OP_LOAD, (pos - 1) >> 3, pos, val);
      else
        send_item(OP_MARK, addr, pos, $urandom_range(255));
    end else begin
      if (loaded_list.size() != 0 && $urandom_range(99) < 70)
        addr = loaded_list[$urandom_range(loaded_list.size() - 1)];
      if (loaded[addr]) send_item(OP_READ, addr, $urandom_range(POS_MAX), $urandom_range(255));
      else send_item(OP_LOAD, addr, $urandom_range(POS_MAX), val);
    end
  endtask

  task automatic test_directed();
    write_regs(0, 0, 1'b1);
    send_item(OP_FIND, 0, 0, 0);                // nothing tracked
    send_item(OP_LOAD, 0, POS_MAX, 8'hA5);
    send_item(OP_LOAD, 1023, 0, 8'h5A);
    send_item(OP_READ, 0, 0, 8'hFF);
    send_item(OP_READ, 1023, POS_MAX, 0);
    send_item(OP_MARK, 1023, 1, 8'hFF);         // count is zero: ignored
    send_item(OP_MARK, 0, 0, 0);                // position zero: ignored
    settle();
    write_regs(7, 0, 1'b0);
    send_item(OP_FIND, 0, 0, 0);                // less than one whole byte
    settle();
    write_regs(16, 0, 1'b0);
    send_item(OP_LOAD, 1, 0, 8'h7F);
    send_item(OP_FIND, 0, 0, 0);
    send_item(OP_MARK, 0, 2, 0);
    send_item(OP_MARK, 0, 16, 0);               // last tracked position
    send_item(OP_MARK, 0, 17, 0);               // just past the count
    send_item(OP_MARK, 0, POS_MAX, 0);
    send_item(OP_FIND, 0, 0, 0);
    send_item(OP_READ, 1, 0, 0);
    settle();
    write_regs(16, 4, 1'b0);
    send_item(OP_FIND, 0, 0, 0);                // first hole above the reserved range
    send_item(OP_LOAD, 0, 0, 8'hFF);
    send_item(OP_FIND, 0, 0, 0);                // all full
    send_item(OP_READ, 0, 0, 0);
    send_item(OP_LOAD, 0, 0, 8'h00);
    send_item(OP_FIND, 0, 0, 0);
  endtask

  task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n_items);
    int bits, rsv;
    send_idle_pct = snd_pct;
    recv_idle_pct <= rcv_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) begin
        settle();
        bits = $urandom_range(0, 1200);
        rsv = ($urandom_range(3) == 0) ? $urandom_range(POS_MAX) : $urandom_range(0, bits);
        write_regs(bits, rsv, 1'b0);
      end
      random_item();
    end
  endtask

  // receiver blocks for a long stretch while items keep coming
  task automatic test_output_stall();
    settle();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_len <= 400;
    hold_req <= hold_req + 1;
    repeat (40) random_item();
    settle();
  endtask

  task automatic test_full_store();
    settle();
    send_idle_pct = 10;
    recv_idle_pct <= 20;
    // fill the rest, mostly in use, so finds run deep
    for (int k = 0; k < BITMAP_BYTES; k++)
      if (!loaded[k])
        send_item(OP_LOAD, k, $urandom_range(POS_MAX),
                  ($urandom_range(99) < 95) ? 8'hFF : $urandom_range(255));
    settle();
    write_regs(POS_MAX, 0, 1'b0);               // count beyond the store saturates
    send_item(OP_FIND, 0, 0, 0);
    send_item(OP_MARK, 0, 8192, 0);
    send_item(OP_MARK, 0, 8193, 0);
    settle();
    write_regs(POS_MAX, POS_MAX, 1'b0);
    send_item(OP_FIND, 0, 0, 0);                // whole store scanned, nothing free
    settle();
    write_regs(8192, 8190, 1'b0);
    send_item(OP_LOAD, 1023, 0, 8'h3F);
    send_item(OP_FIND, 0, 0, 0);
    send_item(OP_MARK, 0, 8191, 0);
    send_item(OP_FIND, 0, 0, 0);
    send_item(OP_READ, 1023, 0, 0);
    for (int i = 0; i < 120; i++) begin
      if (i % 40 == 0) begin
        settle();
        write_regs(8192, $urandom_range(0, 8192), 1'b0);
      end
      random_item();
    end
  endtask

  // receiver and result checker
  always @(posedge clk) begin
    alloc_reply_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected result found=%0d free_position=%0d read_byte=%0h",
                   $time, found, free_position, read_byte);
          errors++;
        end else begin
          want = reply_q.pop_front();
          if (found !== want.found) begin
            $display("%0t: found expected %0d actual %0d", $time, want.found, found);
            errors++;
          end
          if (free_position !== want.pos) begin
            $display("%0t: free_position expected %0d actual %0d", $time, want.pos,
                     free_position);
            errors++;
          end
          if (read_byte !== want.rd) begin
            $display("%0t: read_byte expected %0h actual %0h", $time, want.rd, read_byte);
            errors++;
          end
          if (want.found) n_hits++;
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
               WATCHDOG_LIMIT, reply_q.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_traffic(35, 51, 200);
    test_random_traffic(51, 35, 200);
    test_random_traffic(0, 0, 200);
    test_output_stall();
    test_full_store();
    settle();
    repeat (64) @(posedge clk);
    if (reply_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, reply_q.size());
      errors++;
    end
    n_misses = n_finds - n_hits;
    $display("Ran %0d loads, %0d reads, %0d marks, %0d finds (%0d hit, %0d empty)",
             n_loads, n_reads, n_marks, n_finds, n_hits, n_misses);
    $display("with %0d register writes, %0d of %0d bitmap bytes written, %0d mismatches",
             n_cfg, loaded_list.size(), BITMAP_BYTES, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_ram.sv
hw/rtl/bfa_byte_check.sv
hw/rtl/bitmap_first_free_allocator.sv
hw/rtl/bfa_checker.sv
sim/testbench.sv
